// File: hdl/dtpb_pkg.sv
// ----------------------------------------------------------------------------
// Depth-tested pixel buffer package
// Shared constants, payload types and a helper function.
// ----------------------------------------------------------------------------
package dtpb_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int X_W         = $clog2(MAX_WIDTH);
	localparam int Y_W         = $clog2(MAX_HEIGHT);

	localparam int CFG_W    = 9;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int COLOR_W  = 12;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(256);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(256);

	localparam logic [COLOR_W-1:0] INTENSITY_MAX = COLOR_W'(4095);
	localparam logic [COLOR_W-1:0] BG_BLUE       = COLOR_W'(1000);
	localparam logic [15:0]        BG_ALPHA      = 16'd1;
	localparam logic [31:0]        BG_DEPTH      = 32'h7FFF_FFFF;

	// Register indexes on the configuration port.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} act_t;

	typedef struct packed {
		act_t               action;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] red_in;
		logic signed [15:0] green_in;
		logic signed [15:0] blue_in;
		logic signed [15:0] alpha_in;
		logic signed [31:0] depth_in;
	} item_t;

	typedef struct packed {
		logic               status;
		logic [11:0]        red_out;
		logic [11:0]        green_out;
		logic [11:0]        blue_out;
		logic signed [15:0] alpha_out;
		logic signed [31:0] depth_out;
	} result_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic signed [15:0] alpha;
		logic signed [31:0] depth;
	} pixel_t;

	localparam pixel_t BG_PIXEL = '{
		red:   '0,
		green: '0,
		blue:  BG_BLUE,
		alpha: BG_ALPHA,
		depth: BG_DEPTH
	};

	function automatic logic [COLOR_W-1:0] clamp_intensity(input logic signed [15:0] v);
		logic [COLOR_W-1:0] r;
		if (v[15]) begin
			r = '0;
		end else if (v > 16'sd4095) begin
			r = INTENSITY_MAX;
		end else begin
			r = v[COLOR_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/depth_tested_pixel_buffer.sv
// ----------------------------------------------------------------------------
// Depth-tested pixel buffer
// Z-buffered pixel store with clear, depth-tested write and read items.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the item channel (item_valid/item_ready) and each gives
// exactly one beat on the result channel (result_valid/result_ready).
// The user must write the resolution registers over the APB port only
// while the block is idle; the block does not enforce this. pready is always high.
// Write and read items pass the memory read stage and then the compare and
// write-back stage, whose result is registered in the output register. While
// results are taken, a new write or read item is accepted every cycle, set by
// the single read port of the pixel memory; a write followed at once by an
// access to the same pixel is forwarded.
// A clear item sweeps all 65536 memory entries one entry per cycle, and
// its result follows the last entry; no item is accepted during the sweep.
// The pixel memory is undefined after reset until the first clear; reset
// empties the pipeline and sets both resolutions to 256.
// When the receiver stalls, one finished result waits in the output
// register and one more in a holding register; then item_ready drops.
// ----------------------------------------------------------------------------
module depth_tested_pixel_buffer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  dtpb_pkg::item_t                    item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output dtpb_pkg::result_t                  result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dtpb_pkg::PADDR_W-1:0]       paddr,
	input  logic [dtpb_pkg::PDATA_W-1:0]       pwdata,
	output logic [dtpb_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOOK  = 4'b0010,
		ST_CLEAR = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	typedef struct packed {
		dtpb_pkg::act_t                action;
		logic                          in_range;
		logic [dtpb_pkg::ADDR_W-1:0]   addr;
		dtpb_pkg::pixel_t              pix;
	} work_t;

	state_t                          state_q, state_d;
	logic [dtpb_pkg::CFG_W-1:0]      width_q, height_q;
	logic [dtpb_pkg::CFG_W-1:0]      w_eff, h_eff;
	logic [dtpb_pkg::ADDR_W-1:0]     clr_cnt_q;
	logic [dtpb_pkg::ADDR_W:0]       addr_full;
	logic                            x_ok, y_ok;
	work_t                           work_c, work_s1;
	dtpb_pkg::pixel_t                pixel_mem_q [dtpb_pkg::STORE_DEPTH];
	dtpb_pkg::pixel_t                rd_q, fwd_pix_q, old_pix;
	logic                            fwd_q;
	logic                            accept;
	logic                            slot_free;
	logic                            wr_en;
	logic [dtpb_pkg::ADDR_W-1:0]     wr_addr;
	dtpb_pkg::pixel_t                wr_data;
	dtpb_pkg::result_t               res_c, hold_q, out_q;
	logic                            out_valid_q;
	logic                            load_out;
	logic                            load_hold;
	logic                            cfg_wr;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dtpb_pkg::WIDTH_RESET;
			height_q <= dtpb_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				dtpb_pkg::REG_WIDTH:  width_q  <= pwdata[dtpb_pkg::CFG_W-1:0];
				dtpb_pkg::REG_HEIGHT: height_q <= pwdata[dtpb_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			dtpb_pkg::REG_WIDTH:  prdata = dtpb_pkg::PDATA_W'(width_q);
			dtpb_pkg::REG_HEIGHT: prdata = dtpb_pkg::PDATA_W'(height_q);
			default:              prdata = '0;
		endcase
	end

	// Address and bounds check of the incoming item.
	assign w_eff = (32'(width_q) > dtpb_pkg::MAX_WIDTH) ?
		dtpb_pkg::CFG_W'(dtpb_pkg::MAX_WIDTH) : width_q;
	assign h_eff = (32'(height_q) > dtpb_pkg::MAX_HEIGHT) ?
		dtpb_pkg::CFG_W'(dtpb_pkg::MAX_HEIGHT) : height_q;

	assign x_ok = !item.pos_x[15] && ($unsigned(item.pos_x) < 16'(w_eff));
	assign y_ok = !item.pos_y[15] && ($unsigned(item.pos_y) < 16'(h_eff));

	assign addr_full = (dtpb_pkg::ADDR_W+1)'(item.pos_y[dtpb_pkg::Y_W-1:0])
		* (dtpb_pkg::ADDR_W+1)'(w_eff)
		+ (dtpb_pkg::ADDR_W+1)'(item.pos_x[dtpb_pkg::X_W-1:0]);

	always_comb begin
		work_c.action    = item.action;
		work_c.in_range  = x_ok && y_ok;
		work_c.addr      = addr_full[dtpb_pkg::ADDR_W-1:0];
		work_c.pix.red   = dtpb_pkg::clamp_intensity(item.red_in);
		work_c.pix.green = dtpb_pkg::clamp_intensity(item.green_in);
		work_c.pix.blue  = dtpb_pkg::clamp_intensity(item.blue_in);
		work_c.pix.alpha = item.alpha_in;
		work_c.pix.depth = item.depth_in;
	end

	assign slot_free  = !out_valid_q || result_ready;
	assign item_ready = (state_q == ST_IDLE) || ((state_q == ST_LOOK) && slot_free);
	assign accept     = item_valid && item_ready;

	// Pixel memory: one read and one write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pixel_mem_q[wr_addr] <= wr_data;
		end
		if (accept) begin
			rd_q <= pixel_mem_q[work_c.addr];
		end
	end

	// A write in the same cycle as the read of the same pixel is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (accept) begin
			fwd_q <= wr_en && (wr_addr == work_c.addr);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_pix_q <= wr_data;
			work_s1   <= work_c;
		end
	end

	assign old_pix = fwd_q ? fwd_pix_q : rd_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = work_s1.addr;
		wr_data = work_s1.pix;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = dtpb_pkg::BG_PIXEL;
		end else if (state_q == ST_LOOK) begin
			wr_en = (work_s1.action == dtpb_pkg::ACT_WRITE) && work_s1.in_range
				&& (work_s1.pix.depth < old_pix.depth);
		end
	end

	always_comb begin
		res_c = '0;
		if (state_q == ST_LOOK) begin
			case (work_s1.action)
				dtpb_pkg::ACT_WRITE: begin
					res_c.status = !work_s1.in_range;
				end
				dtpb_pkg::ACT_READ: begin
					res_c.status = !work_s1.in_range;
					if (work_s1.in_range) begin
						res_c.red_out   = old_pix.red;
						res_c.green_out = old_pix.green;
						res_c.blue_out  = old_pix.blue;
						res_c.alpha_out = old_pix.alpha;
						res_c.depth_out = old_pix.depth;
					end
				end
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_comb begin
		state_d   = state_q;
		load_out  = 1'b0;
		load_hold = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (item.action == dtpb_pkg::ACT_CLEAR) ? ST_CLEAR : ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (accept) begin
						state_d = (item.action == dtpb_pkg::ACT_CLEAR) ? ST_CLEAR : ST_LOOK;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					load_hold = 1'b1;
					state_d   = ST_HOLD;
				end
			end
			ST_CLEAR: begin
				if (&clr_cnt_q) begin
					if (slot_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						load_hold = 1'b1;
						state_d   = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_hold) begin
			hold_q <= res_c;
		end
		if (load_out) begin
			out_q <= (state_q == ST_HOLD) ? hold_q : res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Checks.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !item_ready)
		else $error("item accepted during clear sweep");

	a_write_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_LOOK || state_q == ST_CLEAR))
		else $error("memory write outside a working state");

	a_sweep_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.action == dtpb_pkg::ACT_CLEAR
		|=> state_q == ST_CLEAR && clr_cnt_q == '0)
		else $error("clear sweep did not start at entry zero");

	a_hold_only_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD |-> result_valid)
		else $error("holding a result while the output register is empty");

endmodule
